// ===== rtl/bds_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bds_pkg
// shared constants and types of the 2x2 box downscaler
// ----------------------------------------------------------------------------
package bds_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int IDX_W      = $clog2(LINE_DEPTH);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WID_W      = 13;
  localparam int HGT_W      = 16;
  localparam int CH_W       = 3;
  localparam int NUM_CH     = 4;
  localparam int PIX_W      = 8;
  localparam int PAIR_W     = PIX_W + 1;
  localparam int LINE_W     = NUM_CH * PAIR_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH    = 2'd0,
    CFG_HEIGHT   = 2'd1,
    CFG_CHANNELS = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic row_end;
    logic frame_end;
  } blk_flags_t;

endpackage
`default_nettype wire

// ===== rtl/bds_pix_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bds_pix_if
// input pixel channel: valid, ready and four channel bytes
// ----------------------------------------------------------------------------
interface bds_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] chan0;
  logic [7:0] chan1;
  logic [7:0] chan2;
  logic [7:0] chan3;

  modport source (output valid, output chan0, output chan1, output chan2,
                  output chan3, input ready);
  modport sink (input valid, input chan0, input chan1, input chan2,
                input chan3, output ready);
endinterface
`default_nettype wire

// ===== rtl/bds_avg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bds_avg_if
// output channel: valid, ready, four block means and row/frame end marks
// ----------------------------------------------------------------------------
interface bds_avg_if;
  logic       valid;
  logic       ready;
  logic [7:0] avg0;
  logic [7:0] avg1;
  logic [7:0] avg2;
  logic [7:0] avg3;
  logic       row_end;
  logic       frame_end;

  modport source (output valid, output avg0, output avg1, output avg2,
                  output avg3, output row_end, output frame_end, input ready);
  modport sink (input valid, input avg0, input avg1, input avg2, input avg3,
                input row_end, input frame_end, output ready);
endinterface
`default_nettype wire

// ===== rtl/bds_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bds_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module bds_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/box_downscale_2x2_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// box_downscale_2x2_top
// 2x2 box-filter decimation of a raster pixel stream through a pair-sum line
// ----------------------------------------------------------------------------
// throughput: one pixel per clock; a stall on the output holds the input
// order: the line ram is read on the edge that accepts the pixel; the block sum
// is then added and loaded into the output register, which a stall holds back
// reset: counters, left pixel and valid flags clear; registers load defaults
// (width 4096, height 65535, four channels); the line ram is not cleared
// ----------------------------------------------------------------------------
module box_downscale_2x2_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [bds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bds_pkg::CFG_DATA_W-1:0] cfg_data,
  bds_pix_if.sink                             pix,
  bds_avg_if.source                           avg
);
  import bds_pkg::*;

  // configuration
  logic [WID_W-1:0] image_width;
  logic [HGT_W-1:0] image_height;
  logic [CH_W-1:0]  channel_count;

  // stream state
  logic [COL_W-1:0]         column_count;
  logic [HGT_W-1:0]         row_count;
  logic [PIX_W-1:0]         left_pixel [NUM_CH];

  // read stage
  logic                     s1_valid;
  logic [LINE_W-1:0]        s1_pair;
  blk_flags_t               s1_flags;

  // output register
  logic                     out_valid;
  logic [PIX_W-1:0]         out_avg [NUM_CH];
  blk_flags_t               out_flags;

  logic [WID_W-1:0]         eff_w;
  logic [HGT_W-1:0]         eff_h;
  logic [CH_W-1:0]          eff_ch;
  logic [WID_W-1:0]         col_ext;
  logic                     col_last;
  logic                     is_pair;
  logic [IDX_W-1:0]         idx;
  logic [PIX_W-1:0]         px [NUM_CH];
  logic [LINE_W-1:0]        pair;
  logic [LINE_W-1:0]        above;
  logic                     accept;
  logic                     adv;
  logic                     ram_we;
  logic                     ram_re;
  blk_flags_t               flags;
  logic [WID_W-2:0]         half_w;
  logic [HGT_W:0]           row_inc;
  logic [HGT_W:0]           h_even;
  logic [PAIR_W:0]          blk_sum [NUM_CH];

  always_comb begin
    eff_w = image_width;
    if (image_width == '0) begin
      eff_w = WID_W'(1);
    end else if (image_width > WID_W'(MAX_WIDTH)) begin
      eff_w = WID_W'(MAX_WIDTH);
    end
    eff_h = (image_height == '0) ? HGT_W'(1) : image_height;
    eff_ch = channel_count;
    if (channel_count == '0) begin
      eff_ch = CH_W'(1);
    end else if (channel_count > CH_W'(NUM_CH)) begin
      eff_ch = CH_W'(NUM_CH);
    end
  end

  assign px[0] = pix.chan0;
  assign px[1] = (eff_ch > CH_W'(1)) ? pix.chan1 : '0;
  assign px[2] = (eff_ch > CH_W'(2)) ? pix.chan2 : '0;
  assign px[3] = (eff_ch > CH_W'(3)) ? pix.chan3 : '0;

  assign col_ext  = WID_W'(column_count);
  assign col_last = (col_ext + WID_W'(1)) >= eff_w;
  assign is_pair  = column_count[0] && (col_ext < {eff_w[WID_W-1:1], 1'b0});
  assign idx      = column_count[COL_W-1:1];
  assign half_w   = eff_w[WID_W-1:1];
  assign row_inc  = {1'b0, row_count} + (HGT_W+1)'(1);
  assign h_even   = {1'b0, eff_h[HGT_W-1:1], 1'b0};

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      pair[i*PAIR_W +: PAIR_W] = {1'b0, left_pixel[i]} + {1'b0, px[i]};
    end
    flags.row_end   = ((WID_W-1)'(idx) + (WID_W-1)'(1)) == half_w;
    flags.frame_end = flags.row_end && (row_inc == h_even);
  end

  assign adv       = !out_valid || avg.ready;
  assign pix.ready = !s1_valid || adv;
  assign accept    = pix.valid && pix.ready;
  assign ram_we    = accept && is_pair && !row_count[0];
  assign ram_re    = accept && is_pair && row_count[0];

  bds_ram #(
    .WIDTH (LINE_W),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (pair),
    .re    (ram_re),
    .raddr (idx),
    .rdata (above)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= WID_W'(MAX_WIDTH);
      image_height  <= '1;
      channel_count <= CH_W'(NUM_CH);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH:    image_width   <= cfg_data[WID_W-1:0];
        CFG_HEIGHT:   image_height  <= cfg_data[HGT_W-1:0];
        CFG_CHANNELS: channel_count <= cfg_data[CH_W-1:0];
        default: ;
      endcase
    end
  end

  // raster counters and left pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      for (int i = 0; i < NUM_CH; i++) begin
        left_pixel[i] <= '0;
      end
    end else if (accept) begin
      if (!column_count[0]) begin
        left_pixel <= px;
      end
      if (col_last) begin
        column_count <= '0;
        row_count    <= (row_inc >= {1'b0, eff_h}) ? '0 : row_inc[HGT_W-1:0];
      end else begin
        column_count <= column_count + COL_W'(1);
      end
    end
  end

  // read stage and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ram_re) begin
        s1_valid <= 1'b1;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
      if (adv) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      blk_sum[i] = {1'b0, above[i*PAIR_W +: PAIR_W]} + {1'b0, s1_pair[i*PAIR_W +: PAIR_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      s1_pair  <= pair;
      s1_flags <= flags;
    end
    if (adv && s1_valid) begin
      for (int i = 0; i < NUM_CH; i++) begin
        out_avg[i] <= blk_sum[i][PAIR_W:2];
      end
      out_flags <= s1_flags;
    end
  end

  assign avg.valid     = out_valid;
  assign avg.avg0      = out_avg[0];
  assign avg.avg1      = out_avg[1];
  assign avg.avg2      = out_avg[2];
  assign avg.avg3      = out_avg[3];
  assign avg.row_end   = out_flags.row_end;
  assign avg.frame_end = out_flags.frame_end;

endmodule
`default_nettype wire
